@@ src/u8u16_pkg.sv @@
// shared types and constants for the utf-8 to utf-16 transcoder
// no dependencies; imported by every module in src
`timescale 1ns / 1ps

package u8u16_pkg;

	// kind of multi-byte sequence currently open
	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_TWO   = 2'd1,
		KIND_THREE = 2'd2,
		KIND_FOUR  = 2'd3
	} seq_kind_t;

	localparam int UNIT_W    = 16;
	localparam int ACC_W     = 21;
	localparam int MAX_UNITS = 3;

	// lead byte classification
	localparam logic [7:0] LEAD2_MASK  = 8'he0;
	localparam logic [7:0] LEAD2_CODE  = 8'hc0;
	localparam logic [7:0] LEAD3_MASK  = 8'hf0;
	localparam logic [7:0] LEAD3_CODE  = 8'he0;

	// surrogate pair construction
	localparam logic [ACC_W-1:0] SUPP_BASE = 21'h10000;
	localparam logic [5:0]       HI_SURR   = 6'b110110;
	localparam logic [5:0]       LO_SURR   = 6'b110111;

	// up to three code units produced by one input byte, unit 0 goes first
	typedef struct packed {
		logic [MAX_UNITS-1:0][UNIT_W-1:0] unit;
		logic [1:0]                       count;
		logic                             eos;
	} unit_bundle_t;

endpackage

@@ src/u8u16_step.sv @@
// sequence decoder: holds the open utf-8 sequence and turns one byte into its code units
// depends on u8u16_pkg
`timescale 1ns / 1ps

module u8u16_step import u8u16_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [7:0]   byte_in,
	input  logic         eos_in,
	input  logic         advance,
	output unit_bundle_t bundle,
	output logic         seq_open
);

	seq_kind_t        kind_q, kind_d;
	logic [1:0]       expect_q, expect_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [1:0]       hcnt_q, hcnt_d;
	logic [7:0]       held0_q, held0_d;
	logic [7:0]       held1_q, held1_d;

	logic [ACC_W-1:0] acc_shift;
	logic [ACC_W-1:0] supp;

	assign acc_shift = {acc_q[ACC_W-7:0], byte_in[5:0]};
	assign supp      = acc_shift - SUPP_BASE;
	assign seq_open  = (kind_q != KIND_NONE);

	always_comb begin
		kind_d   = kind_q;
		expect_d = expect_q;
		acc_d    = acc_q;
		hcnt_d   = hcnt_q;
		held0_d  = held0_q;
		held1_d  = held1_q;
		bundle   = '0;
		bundle.eos = eos_in;
		case (kind_q)
			KIND_NONE: begin
				if (!byte_in[7] || eos_in) begin
					// ascii, or any other byte that ends the string: pass through raw
					bundle.unit[0] = {8'h00, byte_in};
					bundle.count   = 2'd1;
				end else begin
					if ((byte_in & LEAD2_MASK) == LEAD2_CODE) begin
						kind_d   = KIND_TWO;
						expect_d = 2'd1;
						acc_d    = {16'h0000, byte_in[4:0]};
					end else if ((byte_in & LEAD3_MASK) == LEAD3_CODE) begin
						kind_d   = KIND_THREE;
						expect_d = 2'd2;
						acc_d    = {17'h00000, byte_in[3:0]};
					end else begin
						kind_d   = KIND_FOUR;
						expect_d = 2'd3;
						acc_d    = {18'h00000, byte_in[2:0]};
					end
					held0_d = byte_in;
					hcnt_d  = 2'd1;
				end
			end
			default: begin
				if (eos_in && expect_q > 2'd1) begin
					// string cut short: held bytes then this byte go out raw
					bundle.unit[0] = {8'h00, held0_q};
					if (hcnt_q == 2'd1) begin
						bundle.unit[1] = {8'h00, byte_in};
						bundle.count   = 2'd2;
					end else begin
						bundle.unit[1] = {8'h00, held1_q};
						bundle.unit[2] = {8'h00, byte_in};
						bundle.count   = 2'd3;
					end
					kind_d   = KIND_NONE;
					expect_d = 2'd0;
					acc_d    = '0;
					hcnt_d   = 2'd0;
				end else begin
					acc_d = acc_shift;
					if (hcnt_q == 2'd1) begin
						held1_d = byte_in;
					end
					if (hcnt_q != 2'd3) begin
						hcnt_d = hcnt_q + 2'd1;
					end
					expect_d = expect_q - 2'd1;
					if (expect_q == 2'd1) begin
						if (kind_q == KIND_FOUR && (|acc_shift[ACC_W-1:16])) begin
							bundle.unit[0] = {HI_SURR, supp[19:10]};
							bundle.unit[1] = {LO_SURR, supp[9:0]};
							bundle.count   = 2'd2;
						end else begin
							bundle.unit[0] = acc_shift[UNIT_W-1:0];
							bundle.count   = 2'd1;
						end
						kind_d   = KIND_NONE;
						expect_d = 2'd0;
						acc_d    = '0;
						hcnt_d   = 2'd0;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_NONE;
			expect_q <= 2'd0;
			acc_q    <= '0;
			hcnt_q   <= 2'd0;
		end else if (advance) begin
			kind_q   <= kind_d;
			expect_q <= expect_d;
			acc_q    <= acc_d;
			hcnt_q   <= hcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held0_q <= held0_d;
			held1_q <= held1_d;
		end
	end

endmodule

@@ src/u8u16_emit.sv @@
// result register: holds the code units of one byte and sends them one beat at a time
// depends on u8u16_pkg
`timescale 1ns / 1ps

module u8u16_emit import u8u16_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  unit_bundle_t      bundle,
	input  logic              load,
	output logic              free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [UNIT_W-1:0] m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	logic [1:0]                       rem_q;
	logic [MAX_UNITS-1:0][UNIT_W-1:0] unit_s2;
	logic                             eos_s2;
	logic                             beat;
	logic                             last;

	assign last     = (rem_q == 2'd1);
	assign beat     = m_tvalid && m_tready;
	assign free     = (rem_q == 2'd0) || (beat && last);
	assign m_tvalid = (rem_q != 2'd0);
	assign m_tdata  = unit_s2[0];
	assign m_tuser  = last;
	assign m_tlast  = last && eos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load) begin
			rem_q <= bundle.count;
		end else if (beat) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_s2 <= bundle.unit;
			eos_s2  <= bundle.eos;
		end else if (beat) begin
			unit_s2[0] <= unit_s2[1];
			unit_s2[1] <= unit_s2[2];
		end
	end

endmodule

@@ src/utf8_to_utf16_decoder_top.sv @@
// top level of the utf-8 to utf-16 transcoder: input register, sequence decoder, result register
// depends on u8u16_pkg, u8u16_step, u8u16_emit
`timescale 1ns / 1ps

// Takes a UTF-8 string one byte per beat on the s_ side (s_tlast on the final byte) and
// sends UTF-16 code units on the m_ side. A byte lands in an input register, is decoded
// combinationally against the open sequence, and its 0 to 3 code units are loaded into a
// result register that drains one unit per beat. m_tuser marks the last unit caused by a
// byte; m_tlast marks the final unit of the string. While m_tready stays high, bytes that
// yield at most one unit move at one byte per clock; a surrogate pair (two units) or a
// string cut short inside a sequence (up to three units) keeps the result register busy,
// during which the input register holds one more byte before s_tready drops. Bytes that
// open or extend a sequence produce no beat of their own. Continuation prefixes are not
// checked; a stray continuation or a byte of 0xF8 or above opens a four-byte sequence.
// A byte passes through the input register and then the result register on its way out.
module utf8_to_utf16_decoder_top import u8u16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic        m_tuser,   // [0] last_of_run
	output logic        m_tlast    // string_done
);

	// input register
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         eos_s1;

	unit_bundle_t bundle;
	logic         seq_open;
	logic         emit_free;
	logic         advance;
	logic         load;

	// a byte leaves the input register when its units fit in the result register,
	// or at once if it yields none
	assign advance  = valid_s1 && ((bundle.count == 2'd0) || emit_free);
	assign load     = advance && (bundle.count != 2'd0);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	u8u16_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_s1),
		.eos_in   (eos_s1),
		.advance  (advance),
		.bundle   (bundle),
		.seq_open (seq_open)
	);

	u8u16_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.bundle   (bundle),
		.load     (load),
		.free     (emit_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// the final byte of a string always yields at least one unit
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eos_s1) |-> (bundle.count != 2'd0))
		else $error("final byte produced no code unit");

	// no sequence stays open past the end of a string
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eos_s1) |=> !seq_open)
		else $error("sequence still open after end of string");

	// end of string only on the last unit of a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser)
		else $error("string end flagged on a non-final unit");

	// a byte is loaded into the result register only when it is empty or its last unit is being taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && m_tvalid) |-> (m_tready && m_tuser))
		else $error("result register overwritten before drained");

endmodule
